@@ src/nggap_pkg.sv @@
// Shared types and constants for the GGA position parser.
// Holds character codes, hemisphere codes, conversion constants and the
// job word passed from the sentence parser to the degree converter.
`default_nettype none

package nggap_pkg;

  localparam logic [16:0] ACC_MAX = 17'h1FFFF;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_W      = 8'h57;

  localparam logic [23:0] TAG_GGA = 24'h474741;

  // sentence field numbers
  localparam logic [2:0] FLD_LAT  = 3'd1;
  localparam logic [2:0] FLD_NS   = 3'd2;
  localparam logic [2:0] FLD_LON  = 3'd3;
  localparam logic [2:0] FLD_EW   = 3'd4;
  localparam logic [2:0] FLD_SAT  = 3'd6;
  localparam logic [2:0] FLD_LAST = 3'd7;

  typedef enum logic [1:0] {
    HEMI_NONE = 2'd0,
    HEMI_POS  = 2'd1,
    HEMI_NEG  = 2'd2
  } hemi_t;

  localparam logic [23:0] TEN7 = 24'd10000000;

  // reciprocal of 100, exact for any 17-bit dividend
  localparam logic [17:0] M100       = 18'd167773;
  localparam int          M100_SHIFT = 24;
  // floor(2^30 / 60), low by at most one for a 24-bit dividend
  localparam logic [24:0] M60        = 25'd17895697;

  localparam int SPLIT_W = 18;
  localparam int P_W     = 42;
  localparam int E_W     = 36;

  localparam logic [35:0] LAT_MAX = 36'd900000000;
  localparam logic [35:0] LON_MAX = 36'd1800000000;

  typedef struct packed {
    logic [16:0] lat_whole;
    logic [16:0] lat_frac;
    logic [16:0] lon_whole;
    logic [16:0] lon_frac;
    hemi_t       ns;
    hemi_t       ew;
    logic [7:0]  sat;
  } job_t;

  typedef struct packed {
    hemi_t      ns;
    hemi_t      ew;
    logic [7:0] sat;
  } meta_t;

  function automatic logic [23:0] pow10(input logic [2:0] n);
    logic [23:0] r;
    case (n)
      3'd0: r = 24'd1;
      3'd1: r = 24'd10;
      3'd2: r = 24'd100;
      3'd3: r = 24'd1000;
      3'd4: r = 24'd10000;
      3'd5: r = 24'd100000;
      3'd6: r = 24'd1000000;
      3'd7: r = 24'd10000000;
      default: r = 24'd1;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/nggap_conv.sv @@
// Degree converter for the GGA position parser: ddmm.f / dddmm.f to 1e-7 deg.
// Six-register pipeline with per-stage valid and a stall-propagating ready chain.
// Depends on nggap_pkg.
`default_nettype none

module nggap_conv #(
  parameter int FRAC_DIGITS = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              job_valid,
  output logic                   job_ready,
  input  wire nggap_pkg::job_t   job,
  output logic                   res_valid,
  input  wire logic              res_stall,
  output logic signed [30:0]     latitude_e7,
  output logic signed [31:0]     longitude_e7,
  output logic [1:0]             lat_hemisphere,
  output logic [1:0]             lon_hemisphere,
  output logic [7:0]             satellites,
  output logic                   signs_applied
);

  localparam logic [23:0] K_FRAC = 24'(10 ** (7 - FRAC_DIGITS));
  localparam int SW = nggap_pkg::SPLIT_W;
  localparam int PW = nggap_pkg::P_W;
  localparam int EW = nggap_pkg::E_W;

  // divide a 24-bit value by 60: {quotient, remainder}
  function automatic logic [24:0] div60(input logic [23:0] x);
    logic [48:0] prod;
    logic [18:0] q;
    logic [23:0] r;
    prod = 49'(x) * 49'(nggap_pkg::M60);
    q    = prod[48:30];
    r    = x - (24'({q, 6'b0}) - 24'({q, 2'b0}));
    if (r >= 24'd60) begin
      q = q + 19'd1;
      r = r - 24'd60;
    end
    return {q, r[5:0]};
  endfunction

  // lane 0 latitude, lane 1 longitude
  logic              v1, v2, v3, v4, v5;
  logic              rdy1, rdy2, rdy3, rdy4, rdy5, rdy_o;
  nggap_pkg::meta_t  m1, m2, m3, m4, m5;

  logic [16:0]       whole1 [2];
  logic [16:0]       frac1  [2];
  logic [10:0]       deg2   [2];
  logic [6:0]        rem2   [2];
  logic [16:0]       frac2  [2];
  logic [PW-1:0]     p3     [2];
  logic [10:0]       deg3   [2];
  logic [18:0]       q1_4   [2];
  logic [5:0]        r1_4   [2];
  logic [SW-1:0]     pl4    [2];
  logic [EW-1:0]     degs4  [2];
  logic [EW-1:0]     quot5  [2];
  logic [EW-1:0]     degs5  [2];

  logic [34:0]       prod100 [2];
  logic [10:0]       deg_c   [2];
  logic [16:0]       hund_c  [2];
  logic [6:0]        rem_c   [2];
  logic [PW-1:0]     p_c     [2];
  logic [24:0]       d1_c    [2];
  logic [EW-1:0]     degs_c  [2];
  logic [24:0]       d2_c    [2];
  logic [EW-1:0]     quot_c  [2];
  logic [EW-1:0]     e7_c    [2];
  logic [EW-1:0]     lat_mag, lon_mag;
  logic              both;

  assign rdy_o     = !res_valid || !res_stall;
  assign rdy5      = !v5 || rdy_o;
  assign rdy4      = !v4 || rdy5;
  assign rdy3      = !v3 || rdy4;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign job_ready = rdy1;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      prod100[i] = 35'(whole1[i]) * 35'(nggap_pkg::M100);
      deg_c[i]   = prod100[i][nggap_pkg::M100_SHIFT +: 11];
      hund_c[i]  = 17'({deg_c[i], 6'b0}) + 17'({deg_c[i], 5'b0}) + 17'({deg_c[i], 2'b0});
      rem_c[i]   = 7'(whole1[i] - hund_c[i]);

      p_c[i]     = PW'(rem2[i]) * PW'(nggap_pkg::TEN7)
                 + PW'(frac2[i]) * PW'(K_FRAC) + PW'(30);

      d1_c[i]    = div60(p3[i][PW-1:SW]);
      degs_c[i]  = EW'(deg3[i]) * EW'(nggap_pkg::TEN7);

      d2_c[i]    = div60({r1_4[i], pl4[i]});
      quot_c[i]  = EW'({q1_4[i], {SW{1'b0}}}) + EW'(d2_c[i][24:6]);

      e7_c[i]    = degs5[i] + quot5[i];
    end
    lat_mag = (e7_c[0] > nggap_pkg::LAT_MAX) ? nggap_pkg::LAT_MAX : e7_c[0];
    lon_mag = (e7_c[1] > nggap_pkg::LON_MAX) ? nggap_pkg::LON_MAX : e7_c[1];
    both    = (m5.ns != nggap_pkg::HEMI_NONE) && (m5.ew != nggap_pkg::HEMI_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= job_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
      if (rdy_o) res_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      whole1[0] <= job.lat_whole;
      frac1[0]  <= job.lat_frac;
      whole1[1] <= job.lon_whole;
      frac1[1]  <= job.lon_frac;
      m1        <= '{ns: job.ns, ew: job.ew, sat: job.sat};
    end
    if (rdy2) begin
      deg2  <= deg_c;
      rem2  <= rem_c;
      frac2 <= frac1;
      m2    <= m1;
    end
    if (rdy3) begin
      p3   <= p_c;
      deg3 <= deg2;
      m3   <= m2;
    end
    if (rdy4) begin
      for (int i = 0; i < 2; i++) begin
        q1_4[i] <= d1_c[i][24:6];
        r1_4[i] <= d1_c[i][5:0];
        pl4[i]  <= p3[i][SW-1:0];
      end
      degs4 <= degs_c;
      m4    <= m3;
    end
    if (rdy5) begin
      quot5 <= quot_c;
      degs5 <= degs4;
      m5    <= m4;
    end
    if (rdy_o) begin
      latitude_e7    <= (both && m5.ns == nggap_pkg::HEMI_NEG) ? -31'(lat_mag) : 31'(lat_mag);
      longitude_e7   <= (both && m5.ew == nggap_pkg::HEMI_NEG) ? -32'(lon_mag) : 32'(lon_mag);
      lat_hemisphere <= m5.ns;
      lon_hemisphere <= m5.ew;
      satellites     <= m5.sat;
      signs_applied  <= both;
    end
  end

  a_unsigned_no_sign: assert property (@(posedge clk) disable iff (rst)
    res_valid && !signs_applied |-> !latitude_e7[30] && !longitude_e7[31])
    else $error("negative position without applied signs");

  a_lat_clamped: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (latitude_e7 <= 31'sd900000000) && (latitude_e7 >= -31'sd900000000))
    else $error("latitude beyond 90 degrees");

  a_signs_need_letters: assert property (@(posedge clk) disable iff (rst)
    res_valid && signs_applied |-> (lat_hemisphere != 2'd0) && (lon_hemisphere != 2'd0))
    else $error("signs applied without both hemisphere letters");

endmodule

`default_nettype wire

@@ src/nmea_gga_position_parser_core.sv @@
// Parses an NMEA byte stream and reports GGA positions. The block takes one
// byte per clock; a byte is registered, then parsed from that register, so a
// new byte is accepted every cycle as long as the result side keeps up. Each
// carriage return that closes a GGA body launches one conversion job through the
// degree converter stages (input register, divide by 100, scale, two
// divide-by-60 halves, add and clamp); the result word is registered at the
// last of them. A stalled result backs up through the converter stages, and the
// input stalls only once those stages are all full.
`default_nettype none

module nmea_gga_position_parser_core #(
  parameter int FRAC_DIGITS = 5
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          rx_valid,
  output logic               rx_stall,
  input  wire logic [7:0]    rx_byte,
  output logic               res_valid,
  input  wire logic          res_stall,
  output logic signed [30:0] latitude_e7,
  output logic signed [31:0] longitude_e7,
  output logic [1:0]         lat_hemisphere,
  output logic [1:0]         lon_hemisphere,
  output logic [7:0]         satellites,
  output logic               signs_applied
);

  logic                    byte_valid;
  logic [7:0]              byte_q;
  logic                    parse_go;
  logic                    job_valid;
  logic                    job_ready;
  nggap_pkg::job_t         job;

  logic [23:0]             tag_window, tag_window_next;
  logic                    in_body, in_body_next;
  logic [2:0]              field_number, field_number_next;
  logic [16:0]             whole_accum, whole_accum_next;
  logic [16:0]             frac_accum, frac_accum_next;
  logic [2:0]              frac_digits_seen, frac_digits_seen_next;
  logic                    after_point, after_point_next;
  logic [1:0]              char_count, char_count_next;
  logic [16:0]             lat_whole, lat_whole_next;
  logic [16:0]             lat_frac, lat_frac_next;
  logic [16:0]             lon_whole, lon_whole_next;
  logic [16:0]             lon_frac, lon_frac_next;
  nggap_pkg::hemi_t        ns_code, ns_code_next;
  nggap_pkg::hemi_t        ew_code, ew_code_next;
  logic [7:0]              sat_value, sat_value_next;

  logic [40:0]             pad_prod;
  logic [16:0]             padded;
  logic [16:0]             lat_whole_c, lat_frac_c, lon_whole_c, lon_frac_c;
  logic [7:0]              sat_c;
  logic                    is_digit;
  logic [3:0]              digit;
  logic [20:0]             whole_x10, frac_x10;
  logic                    clr_sentence, clr_field;

  assign parse_go = byte_valid && job_ready;
  assign rx_stall = byte_valid && !parse_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!rx_stall) begin
      byte_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rx_stall && rx_valid) begin
      byte_q <= rx_byte;
    end
  end

  // field commit: what a comma writes back and a carriage return sends in the job
  always_comb begin
    pad_prod = 41'(frac_accum) * 41'(nggap_pkg::pow10(3'(FRAC_DIGITS) - frac_digits_seen));
    padded   = (|pad_prod[40:17]) ? nggap_pkg::ACC_MAX : pad_prod[16:0];
    lat_whole_c = (field_number == nggap_pkg::FLD_LAT) ? whole_accum : lat_whole;
    lat_frac_c  = (field_number == nggap_pkg::FLD_LAT) ? padded : lat_frac;
    lon_whole_c = (field_number == nggap_pkg::FLD_LON) ? whole_accum : lon_whole;
    lon_frac_c  = (field_number == nggap_pkg::FLD_LON) ? padded : lon_frac;
    if (field_number == nggap_pkg::FLD_SAT) begin
      sat_c = (whole_accum > 17'd255) ? 8'd255 : whole_accum[7:0];
    end else begin
      sat_c = sat_value;
    end
  end

  always_comb begin
    tag_window_next       = tag_window;
    in_body_next          = in_body;
    field_number_next     = field_number;
    whole_accum_next      = whole_accum;
    frac_accum_next       = frac_accum;
    frac_digits_seen_next = frac_digits_seen;
    after_point_next      = after_point;
    char_count_next       = char_count;
    lat_whole_next        = lat_whole;
    lat_frac_next         = lat_frac;
    lon_whole_next        = lon_whole;
    lon_frac_next         = lon_frac;
    ns_code_next          = ns_code;
    ew_code_next          = ew_code;
    sat_value_next        = sat_value;
    clr_sentence          = 1'b0;
    clr_field             = 1'b0;
    job_valid             = 1'b0;

    is_digit  = (byte_q >= nggap_pkg::CH_ZERO) && (byte_q <= nggap_pkg::CH_NINE);
    digit     = 4'(byte_q - nggap_pkg::CH_ZERO);
    whole_x10 = 21'(whole_accum) * 21'd10 + 21'(digit);
    frac_x10  = 21'(frac_accum) * 21'd10 + 21'(digit);

    job.lat_whole = lat_whole_c;
    job.lat_frac  = lat_frac_c;
    job.lon_whole = lon_whole_c;
    job.lon_frac  = lon_frac_c;
    job.ns        = ns_code;
    job.ew        = ew_code;
    job.sat       = sat_c;

    if (byte_q == nggap_pkg::CH_DOLLAR) begin
      tag_window_next = '0;
      in_body_next    = 1'b0;
      clr_sentence    = 1'b1;
    end else if (!in_body) begin
      // test the window before shifting; drop the byte after the tag
      if (tag_window == nggap_pkg::TAG_GGA) begin
        in_body_next    = 1'b1;
        tag_window_next = '0;
        clr_sentence    = 1'b1;
      end else begin
        tag_window_next = {tag_window[15:0], byte_q};
      end
    end else if (byte_q == nggap_pkg::CH_COMMA) begin
      lat_whole_next = lat_whole_c;
      lat_frac_next  = lat_frac_c;
      lon_whole_next = lon_whole_c;
      lon_frac_next  = lon_frac_c;
      sat_value_next = sat_c;
      if (field_number != nggap_pkg::FLD_LAST) begin
        field_number_next = field_number + 3'd1;
      end
      clr_field = 1'b1;
    end else if (byte_q == nggap_pkg::CH_CR) begin
      job_valid       = byte_valid;
      in_body_next    = 1'b0;
      tag_window_next = '0;
      clr_sentence    = 1'b1;
    end else begin
      if (char_count != 2'd3) begin
        char_count_next = char_count + 2'd1;
      end
      if (field_number == nggap_pkg::FLD_NS) begin
        if (char_count_next == 2'd1 && byte_q == nggap_pkg::CH_N) begin
          ns_code_next = nggap_pkg::HEMI_POS;
        end else if (char_count_next == 2'd1 && byte_q == nggap_pkg::CH_S) begin
          ns_code_next = nggap_pkg::HEMI_NEG;
        end else begin
          ns_code_next = nggap_pkg::HEMI_NONE;
        end
      end else if (field_number == nggap_pkg::FLD_EW) begin
        if (char_count_next == 2'd1 && byte_q == nggap_pkg::CH_E) begin
          ew_code_next = nggap_pkg::HEMI_POS;
        end else if (char_count_next == 2'd1 && byte_q == nggap_pkg::CH_W) begin
          ew_code_next = nggap_pkg::HEMI_NEG;
        end else begin
          ew_code_next = nggap_pkg::HEMI_NONE;
        end
      end
      if (is_digit) begin
        if (!after_point) begin
          whole_accum_next = (|whole_x10[20:17]) ? nggap_pkg::ACC_MAX : whole_x10[16:0];
        end else if (frac_digits_seen < 3'(FRAC_DIGITS)) begin
          frac_accum_next       = (|frac_x10[20:17]) ? nggap_pkg::ACC_MAX : frac_x10[16:0];
          frac_digits_seen_next = frac_digits_seen + 3'd1;
        end
      end else if (byte_q == nggap_pkg::CH_POINT) begin
        after_point_next = 1'b1;
      end
    end

    if (clr_sentence) begin
      field_number_next = '0;
      lat_whole_next    = '0;
      lat_frac_next     = '0;
      lon_whole_next    = '0;
      lon_frac_next     = '0;
      ns_code_next      = nggap_pkg::HEMI_NONE;
      ew_code_next      = nggap_pkg::HEMI_NONE;
      sat_value_next    = '0;
    end
    if (clr_sentence || clr_field) begin
      whole_accum_next      = '0;
      frac_accum_next       = '0;
      frac_digits_seen_next = '0;
      after_point_next      = 1'b0;
      char_count_next       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_window       <= '0;
      in_body          <= 1'b0;
      field_number     <= '0;
      whole_accum      <= '0;
      frac_accum       <= '0;
      frac_digits_seen <= '0;
      after_point      <= 1'b0;
      char_count       <= '0;
      lat_whole        <= '0;
      lat_frac         <= '0;
      lon_whole        <= '0;
      lon_frac         <= '0;
      ns_code          <= nggap_pkg::HEMI_NONE;
      ew_code          <= nggap_pkg::HEMI_NONE;
      sat_value        <= '0;
    end else if (parse_go) begin
      tag_window       <= tag_window_next;
      in_body          <= in_body_next;
      field_number     <= field_number_next;
      whole_accum      <= whole_accum_next;
      frac_accum       <= frac_accum_next;
      frac_digits_seen <= frac_digits_seen_next;
      after_point      <= after_point_next;
      char_count       <= char_count_next;
      lat_whole        <= lat_whole_next;
      lat_frac         <= lat_frac_next;
      lon_whole        <= lon_whole_next;
      lon_frac         <= lon_frac_next;
      ns_code          <= ns_code_next;
      ew_code          <= ew_code_next;
      sat_value        <= sat_value_next;
    end
  end

  nggap_conv #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_conv (
    .clk            (clk),
    .rst            (rst),
    .job_valid      (job_valid),
    .job_ready      (job_ready),
    .job            (job),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .latitude_e7    (latitude_e7),
    .longitude_e7   (longitude_e7),
    .lat_hemisphere (lat_hemisphere),
    .lon_hemisphere (lon_hemisphere),
    .satellites     (satellites),
    .signs_applied  (signs_applied)
  );

  a_window_idle_in_body: assert property (@(posedge clk) disable iff (rst)
    in_body |-> tag_window == '0)
    else $error("tag window not clear inside a sentence body");

  a_fields_idle_outside: assert property (@(posedge clk) disable iff (rst)
    !in_body |-> field_number == '0)
    else $error("field count moved outside a sentence body");

  a_frac_digit_bound: assert property (@(posedge clk) disable iff (rst)
    frac_digits_seen <= 3'(FRAC_DIGITS))
    else $error("more fraction digits taken than configured");

endmodule

`default_nettype wire
